// ----- rtl/integer_to_radix_digits_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the integer to radix digits unit.
// Clocked implication checks, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_UNIT_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITRD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/itrd_pkg.sv -----
// ---------------------------------------------------------------------------
// itrd_pkg
// Shared widths, character codes and types of the radix digits unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itrd_pkg;

  localparam int VALUE_W     = 64;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 6;
  localparam int MAX_DIGITS  = 64;
  localparam int ADDR_W      = $clog2(MAX_DIGITS);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int STEP_W      = $clog2(VALUE_W);
  localparam int S_DATA_W    = ((VALUE_W + RADIX_W + 7) / 8) * 8;
  localparam int M_DATA_W    = ((CHAR_W + 7) / 8) * 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(35);
  localparam logic [RADIX_W-1:0] DECIMAL   = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] ZERO_CHAR   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] LETTER_BIAS = CHAR_W'(87);
  localparam logic [CHAR_W-1:0] MINUS_CHAR  = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] ERROR_CHAR  = CHAR_W'(0);

  typedef struct packed {
    logic busy;
    logic done;
  } itrd_div_status_t;

  // Digit value to its ASCII character: decimal digits, then lower case.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DIGIT_W'(10)) begin
      digit_char = dx + ZERO_CHAR;
    end else begin
      digit_char = dx + LETTER_BIAS;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/itrd_ram.sv -----
// ---------------------------------------------------------------------------
// itrd_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/itrd_divider.sv -----
// ---------------------------------------------------------------------------
// itrd_divider
// Restoring divider, one quotient bit per cycle, 64-bit dividend by radix.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itrd_divider (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [itrd_pkg::VALUE_W-1:0]     dividend,
  input  wire logic [itrd_pkg::RADIX_W-1:0]     divisor,
  output itrd_pkg::itrd_div_status_t            status,
  output logic      [itrd_pkg::VALUE_W-1:0]     quotient,
  output logic      [itrd_pkg::DIGIT_W-1:0]     remainder
);

  logic [itrd_pkg::VALUE_W-1:0] sh;
  logic [itrd_pkg::RADIX_W-1:0] rem;
  logic [itrd_pkg::RADIX_W-1:0] dvs;
  logic [itrd_pkg::STEP_W-1:0]  step;
  logic                         busy;
  logic                         done;
  logic [itrd_pkg::RADIX_W:0]   trial;
  logic                         ge;
  logic [itrd_pkg::RADIX_W:0]   diff;

  // The remainder stays below the divisor, so the trial fits one extra bit.
  always_comb begin
    trial = {rem, sh[itrd_pkg::VALUE_W-1]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sh   <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        sh   <= {sh[itrd_pkg::VALUE_W-2:0], ge};
        rem  <= ge ? diff[itrd_pkg::RADIX_W-1:0] : trial[itrd_pkg::RADIX_W-1:0];
        step <= step + 1'b1;
        if (step == {itrd_pkg::STEP_W{1'b1}}) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = sh;
  assign remainder   = rem[itrd_pkg::DIGIT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/integer_to_radix_digits_unit.sv -----
// ---------------------------------------------------------------------------
// integer_to_radix_digits_unit
// Converts a 64-bit value to its ASCII digit string in base 2 to 35.
// ---------------------------------------------------------------------------
// Usage. A transaction on the slave channel carries a value and a radix. The
// unit answers with the digit string on the master channel, one character per
// transaction, most significant digit first, with tlast on the final one. In
// base ten the value is signed and a negative value starts with '-'. A radix
// outside 2..35 gives one transaction with character zero, tuser and tlast set.
//
// Operation. Each digit costs one pass of the shared bit-serial divider, 64 steps
// plus a handoff to the next pass. The digits land in a 64-entry store least
// significant first and are read back in reverse, each character taking a
// read state and an emit state because of the registered RAM read. The unit
// takes one value at a time and raises s_tready only when idle.
//
// Reset clears the sequencer and drops m_tvalid; the digit store is not
// cleared since every digit is written before it is read. When the receiver
// holds m_tready low the current character stays on the port and the
// sequencer waits before it loads another character.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_radix_digits_unit_assert.svh"

module integer_to_radix_digits_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // s_tdata fields from bit 0: value[63:0], radix[69:64], zero fill.
  input  wire logic [itrd_pkg::S_DATA_W-1:0]     s_tdata,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // m_tdata fields from bit 0: character[7:0].
  output logic      [itrd_pkg::M_DATA_W-1:0]     m_tdata,
  // m_tuser fields from bit 0: error.
  output logic                                   m_tuser,
  output logic                                   m_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ERR  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_SIGN = 6'b001000,
    ST_RD   = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t                              state;
  logic [itrd_pkg::COUNT_W-1:0]        count;
  logic [itrd_pkg::ADDR_W-1:0]         idx;
  logic                                negative;
  logic [itrd_pkg::RADIX_W-1:0]        radix;

  logic [itrd_pkg::VALUE_W-1:0]        value_in;
  logic [itrd_pkg::RADIX_W-1:0]        radix_in;
  logic                                accept;
  logic                                radix_ok;
  logic                                neg_in;
  logic [itrd_pkg::VALUE_W-1:0]        mag_in;
  logic                                out_free;
  logic                                emit;

  itrd_pkg::itrd_div_status_t          div_status;
  logic                                div_start;
  logic                                div_again;
  logic [itrd_pkg::VALUE_W-1:0]        div_dividend;
  logic [itrd_pkg::RADIX_W-1:0]        div_divisor;
  logic [itrd_pkg::VALUE_W-1:0]        div_quotient;
  logic [itrd_pkg::DIGIT_W-1:0]        div_remainder;

  logic                                ram_we;
  logic                                ram_re;
  logic [itrd_pkg::DIGIT_W-1:0]        ram_rdata;

  always_comb begin
    value_in = s_tdata[itrd_pkg::VALUE_W-1:0];
    radix_in = s_tdata[itrd_pkg::VALUE_W +: itrd_pkg::RADIX_W];
    s_tready = (state == ST_IDLE);
    accept   = s_tvalid && s_tready;
    radix_ok = (radix_in >= itrd_pkg::RADIX_MIN) && (radix_in <= itrd_pkg::RADIX_MAX);
    // Negating the most negative value wraps to 2^63, which is its magnitude.
    neg_in   = (radix_in == itrd_pkg::DECIMAL) && value_in[itrd_pkg::VALUE_W-1];
    mag_in   = neg_in ? (itrd_pkg::VALUE_W'(0) - value_in) : value_in;
    out_free = !m_tvalid || m_tready;
    // A new character is loaded whenever an emitting state finds the port free.
    emit     = out_free &&
               ((state == ST_ERR) || (state == ST_SIGN) || (state == ST_EMIT));

    // Keep dividing while the running quotient is nonzero. The input bus may
    // already carry the next value, so later passes use the stored radix.
    div_again    = (state == ST_DIV) && div_status.done && (div_quotient != '0);
    div_start    = (accept && radix_ok) || div_again;
    div_dividend = accept ? mag_in : div_quotient;
    div_divisor  = accept ? radix_in : radix;

    ram_we = (state == ST_DIV) && div_status.done && !count[itrd_pkg::COUNT_W-1];
    ram_re = (state == ST_RD);
  end

  itrd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .status    (div_status),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  itrd_ram #(
    .WIDTH (itrd_pkg::DIGIT_W),
    .DEPTH (itrd_pkg::MAX_DIGITS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[itrd_pkg::ADDR_W-1:0]),
    .wdata (div_remainder),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
      idx      <= '0;
      negative <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!radix_ok) begin
              state <= ST_ERR;
            end else begin
              negative <= neg_in;
              radix    <= radix_in;
              count    <= '0;
              state    <= ST_DIV;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            m_tdata  <= itrd_pkg::M_DATA_W'(itrd_pkg::ERROR_CHAR);
            m_tlast  <= 1'b1;
            m_tuser  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_status.done) begin
            if (!count[itrd_pkg::COUNT_W-1]) begin
              count <= count + 1'b1;
              idx   <= count[itrd_pkg::ADDR_W-1:0];
            end
            if (div_quotient == '0) begin
              state <= negative ? ST_SIGN : ST_RD;
            end
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            m_tdata  <= itrd_pkg::M_DATA_W'(itrd_pkg::MINUS_CHAR);
            m_tlast  <= 1'b0;
            m_tuser  <= 1'b0;
            state    <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // The read data register holds until the next read, so a stall is safe.
          if (out_free) begin
            m_tdata  <= itrd_pkg::M_DATA_W'(itrd_pkg::digit_char(ram_rdata));
            m_tlast  <= (idx == '0);
            m_tuser  <= 1'b0;
            if (idx == '0) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx - 1'b1;
              state <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The divider never runs while a new value can be taken.
  `ITRD_ASSERT_SAME(a_idle_div_quiet, clk, rst, s_tready, !div_status.busy, "div busy in idle")

  // Results of the divider are only consumed while dividing.
  `ITRD_ASSERT_SAME(a_done_in_div, clk, rst, div_status.done, state == ST_DIV, "stray div done")

  // The digit store never overflows.
  `ITRD_ASSERT_SAME(a_count_max, clk, rst, 1'b1,
                    count <= itrd_pkg::COUNT_W'(itrd_pkg::MAX_DIGITS), "digit count overflow")

  // An error transaction is always a lone, final zero character.
  `ITRD_ASSERT_SAME(a_err_form, clk, rst, m_tvalid && m_tuser,
                    m_tlast && (m_tdata == '0), "malformed error result")

  // Leaving the error state always presents a result.
  `ITRD_ASSERT_NEXT(a_err_out, clk, rst, (state == ST_ERR) && out_free,
                    m_tvalid && m_tuser, "error result missing")

endmodule

`default_nettype wire

// ----- tb/tb_integer_to_radix_digits_unit.sv -----
// ---------------------------------------------------------------------------
// tb_integer_to_radix_digits_unit
// Self-checking bench for the integer to radix digits unit.
// ---------------------------------------------------------------------------
// Every value the unit accepts is expanded into its expected digit string by
// a scoreboard. Each output transaction is compared field by field with the
// oldest pending character. A directed set of edge values comes first. A long
// random phase follows. It uses random idling on both channels, one stretch
// with no idling and one long hold on the output channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// One expected output transaction.
typedef struct packed {
  logic [7:0] character;
  logic       last;
  logic       error;
} expected_char_t;

class digit_string_tracker;
  expected_char_t pending_q[$];
  int fail_count;
  int values_seen;
  int chars_seen;
  int invalid_seen;
  int negative_seen;

  function new();
    fail_count    = 0;
    values_seen   = 0;
    chars_seen    = 0;
    invalid_seen  = 0;
    negative_seen = 0;
  endfunction

  function int pending();
    return pending_q.size();
  endfunction

  // Expands an accepted value into the characters the unit must send.
  function void note_value(input logic [63:0] value, input logic [5:0] radix);
    logic [5:0]     digits [0:63];
    logic [63:0]    mag;
    logic [63:0]    base;
    logic           neg;
    logic [7:0]     dch;
    expected_char_t item;
    int             n;
    int             k;
    values_seen++;
    if (radix < itrd_pkg::RADIX_MIN || radix > itrd_pkg::RADIX_MAX) begin
      item.character = itrd_pkg::ERROR_CHAR;
      item.last      = 1'b1;
      item.error     = 1'b1;
      pending_q.push_back(item);
      invalid_seen++;
      return;
    end
    // Only base ten reads the value as signed; the most negative value
    // wraps to 2^63, which is its correct magnitude as unsigned.
    neg  = (radix == itrd_pkg::DECIMAL) && value[63];
    mag  = neg ? (64'd0 - value) : value;
    base = 64'(radix);
    n    = 0;
    do begin
      digits[n] = 6'(mag % base);
      n++;
      mag = mag / base;
    end while (mag != 64'd0);
    if (neg) begin
      item.character = itrd_pkg::MINUS_CHAR;
      item.last      = 1'b0;
      item.error     = 1'b0;
      pending_q.push_back(item);
      negative_seen++;
    end
    for (k = n - 1; k >= 0; k--) begin
      dch = {2'b00, digits[k]};
      if (digits[k] < 6'd10) begin
        dch = dch + itrd_pkg::ZERO_CHAR;
      end else begin
        dch = dch + itrd_pkg::LETTER_BIAS;
      end
      item.character = dch;
      item.last      = (k == 0);
      item.error     = 1'b0;
      pending_q.push_back(item);
    end
  endfunction

  // Compares one output transaction with the oldest pending character.
  function void check_char(input logic [7:0] ch, input logic last, input logic err);
    expected_char_t want;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected transaction, expected none, actual char 0x%02h last %0b error %0b",
               $time, ch, last, err);
      fail_count++;
      return;
    end
    want = pending_q.pop_front();
    chars_seen++;
    if (want.character !== ch) begin
      $display("%0t: character expected 0x%02h actual 0x%02h",
               $time, want.character, ch);
      fail_count++;
    end
    if (want.last !== last) begin
      $display("%0t: tlast expected %0b actual %0b", $time, want.last, last);
      fail_count++;
    end
    if (want.error !== err) begin
      $display("%0t: error flag expected %0b actual %0b", $time, want.error, err);
      fail_count++;
    end
  endfunction
endclass

module tb_integer_to_radix_digits_unit;

  // Cycles with no transaction on either channel before the run is abandoned.
  // A 64-digit binary conversion alone is silent until all its digits are divided.
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int HOLD_CYCLES    = 500;
  localparam int RANDOM_ITEMS   = 310;
  localparam int IDLE_PCT       = 34;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic [itrd_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [itrd_pkg::M_DATA_W-1:0] m_tdata;
  logic                          m_tuser;
  logic                          m_tlast;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;

  // Stimulus shaping, written by the main sequence.
  logic idle_on    = 1'b1;
  logic stall_arm  = 1'b0;
  logic stall_done = 1'b0;
  int   hold_left  = 0;
  int   quiet_cycles = 0;

  digit_string_tracker board = new();

  integer_to_radix_digits_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both channels are watched at the same edge. An output can never stem from
  // the input accepted at that same edge, so noting first is only for order.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        board.note_value(s_tdata[itrd_pkg::VALUE_W-1:0],
                         s_tdata[itrd_pkg::VALUE_W +: itrd_pkg::RADIX_W]);
      end
      if (m_tvalid && m_tready) begin
        board.check_char(m_tdata[itrd_pkg::CHAR_W-1:0], m_tlast, m_tuser);
      end
    end
  end

  // Receiver. Once armed, it waits for a pending character and then holds
  // tready low for a long stretch. The unit then cannot drain, so it keeps
  // s_tready low while the sender goes on offering.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_arm && !stall_done && m_tvalid) begin
      m_tready   <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      stall_done <= 1'b1;
    end else if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles in which no transaction completes on either channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one value and returns at the edge where it was accepted. tvalid
  // stays high on return, so back-to-back offers drop it only when idling.
  task automatic offer_value(input logic [63:0] v, input logic [5:0] r);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {{(itrd_pkg::S_DATA_W - itrd_pkg::VALUE_W - itrd_pkg::RADIX_W){1'b0}}, r, v};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
  endtask

  // Random value and radix. Most items use a valid base, with decimal
  // weighted up. The value is shifted right by a random amount so that
  // short strings dominate, and a decimal value is negated half the time.
  task automatic offer_random();
    logic [63:0] v;
    logic [5:0]  r;
    int          pick;
    v    = {$urandom, $urandom} >> $urandom_range(0, 63);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      r = $urandom_range(0, 1) ? 6'($urandom_range(0, 1)) : 6'($urandom_range(36, 63));
    end else if (pick < 38) begin
      r = itrd_pkg::DECIMAL;
    end else begin
      r = 6'($urandom_range(2, 35));
    end
    if (r == itrd_pkg::DECIMAL && $urandom_range(0, 1)) begin
      v = 64'd0 - v;
    end
    offer_value(v, r);
  endtask

  initial begin
    int i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero in the smallest, decimal and largest bases.
    offer_value(64'd0, itrd_pkg::RADIX_MIN);
    offer_value(64'd0, itrd_pkg::DECIMAL);
    offer_value(64'd0, itrd_pkg::RADIX_MAX);
    // All ones: 64 binary digits, unsigned in base 16 and 35, -1 in decimal.
    offer_value({64{1'b1}}, itrd_pkg::RADIX_MIN);
    offer_value({64{1'b1}}, 6'd16);
    offer_value({64{1'b1}}, itrd_pkg::RADIX_MAX);
    offer_value({64{1'b1}}, itrd_pkg::DECIMAL);
    // The most negative and most positive decimals, and one plain negative.
    offer_value(64'h8000_0000_0000_0000, itrd_pkg::DECIMAL);
    offer_value(64'h7fff_ffff_ffff_ffff, itrd_pkg::DECIMAL);
    offer_value(64'd0 - 64'd12345, itrd_pkg::DECIMAL);
    // The top bit alone is unsigned outside base ten.
    offer_value(64'h8000_0000_0000_0000, 6'd16);
    offer_value(64'h8000_0000_0000_0000, 6'd9);
    // Digit boundaries: '9', 'a' and 'y', and a full base 3 string.
    offer_value(64'd9, itrd_pkg::DECIMAL);
    offer_value(64'd10, 6'd11);
    offer_value(64'd34, itrd_pkg::RADIX_MAX);
    offer_value(64'd1234567890, 6'd36 - 6'd1);
    offer_value({64{1'b1}}, 6'd3);
    // Bases outside the valid range.
    offer_value(64'd0, 6'd0);
    offer_value(64'd5, 6'd1);
    offer_value(64'hdead_beef_0000_0001, 6'd36);
    offer_value({64{1'b1}}, 6'd63);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // A stretch of full-rate traffic on both channels in the middle.
      idle_on <= !(i >= 120 && i < 190);
      if (i == 40) begin
        stall_arm <= 1'b1;
      end
      offer_random();
    end
    s_tvalid <= 1'b0;

    while (board.pending() != 0) begin
      @(posedge clk);
    end
    // Trailing cycles to catch any surplus output transaction.
    repeat (200) @(posedge clk);

    $display("Covered %0d values: %0d with an invalid base, %0d negative decimals.",
             board.values_seen, board.invalid_seen, board.negative_seen);
    $display("Checked %0d characters, including one %0d-cycle output hold.",
             board.chars_seen, HOLD_CYCLES);
    if (board.fail_count == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
